// ----- hdl/line_rasterizer_assert.svh -----
// Assertion macros shared by the line rasterizer modules.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define LR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_rasterizer: same-cycle check failed");

// Next-cycle implication.
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_rasterizer: next-cycle check failed");

`endif

// ----- hdl/lr_pkg.sv -----
package lr_pkg;

   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] pen_color;
   } lr_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_pixel;
   } lr_rsp_type;

endpackage

// ----- hdl/lr_walker.sv -----
module lr_walker
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  lr_req_type item,
   input  logic       result_blocked,
   output logic       item_done,
   output logic       emit,
   output lr_rsp_type pixel
);

   localparam int EW = COORD_BITS + 2;

   logic                  active_ff, active_in;
   logic                  steep_ff, steep_in;
   logic [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic                  minor_down_ff, minor_down_in;
   logic [COORD_BITS:0]   twice_dx_ff, twice_dx_in;
   logic [COORD_BITS:0]   twice_dy_ff, twice_dy_in;
   logic signed [EW-1:0]  error_ff, error_in;
   logic [COLOR_W-1:0]    color_ff, color_in;

   logic [COORD_BITS-1:0] sx, sy, ex, ey;
   logic [COORD_BITS-1:0] span_x, span_y;
   logic                  steep;
   logic [COORD_BITS-1:0] a0r, b0r, a1r, b1r;
   logic [COORD_BITS-1:0] a0, b0, a1, b1;
   logic                  swap;
   logic [COORD_BITS-1:0] major_span, minor_span;
   logic                  is_start, last;
   logic signed [EW-1:0]  error_sub;
   logic [COORD_BITS-1:0] px, py;

   // line setup
   assign sx = item.start_x[COORD_BITS-1:0];
   assign sy = item.start_y[COORD_BITS-1:0];
   assign ex = item.end_x[COORD_BITS-1:0];
   assign ey = item.end_y[COORD_BITS-1:0];

   assign span_x = (ex > sx) ? (ex - sx) : (sx - ex);
   assign span_y = (ey > sy) ? (ey - sy) : (sy - ey);
   assign steep  = span_y > span_x;

   assign a0r = steep ? sy : sx;
   assign b0r = steep ? sx : sy;
   assign a1r = steep ? ey : ex;
   assign b1r = steep ? ex : ey;

   assign swap = a0r > a1r;
   assign a0   = swap ? a1r : a0r;
   assign b0   = swap ? b1r : b0r;
   assign a1   = swap ? a0r : a1r;
   assign b1   = swap ? b0r : b1r;

   assign major_span = a1 - a0;
   assign minor_span = (b1 > b0) ? (b1 - b0) : (b0 - b1);

   // step
   assign is_start  = (item.kind == KIND_START);
   assign last      = (major_pos_ff == major_end_ff);
   assign error_sub = error_ff - $signed({1'b0, twice_dy_ff});

   assign item_done = item_valid && (is_start || !active_ff || !result_blocked);
   assign emit      = item_valid && !is_start && active_ff && !result_blocked;

   assign px = steep_ff ? minor_pos_ff : major_pos_ff;
   assign py = steep_ff ? major_pos_ff : minor_pos_ff;

   always_comb begin
      pixel.pixel_x     = COORD_W'(px);
      pixel.pixel_y     = COORD_W'(py);
      pixel.pixel_color = color_ff;
      pixel.last_pixel  = last;
   end

   always_comb begin
      active_in     = active_ff;
      steep_in      = steep_ff;
      major_pos_in  = major_pos_ff;
      minor_pos_in  = minor_pos_ff;
      major_end_in  = major_end_ff;
      minor_down_in = minor_down_ff;
      twice_dx_in   = twice_dx_ff;
      twice_dy_in   = twice_dy_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      if (item_valid && is_start) begin
         active_in     = 1'b1;
         steep_in      = steep;
         major_pos_in  = a0;
         minor_pos_in  = b0;
         major_end_in  = a1;
         minor_down_in = !(b0 < b1);
         twice_dx_in   = {major_span, 1'b0};
         twice_dy_in   = {minor_span, 1'b0};
         error_in      = $signed({2'b00, major_span});
         color_in      = item.pen_color;
      end else if (emit) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + 1'b1;
            if (error_sub[EW-1]) begin
               minor_pos_in = minor_down_ff ? (minor_pos_ff - 1'b1) : (minor_pos_ff + 1'b1);
               error_in     = error_sub + $signed({1'b0, twice_dx_ff});
            end else begin
               error_in = error_sub;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      steep_ff      <= steep_in;
      major_pos_ff  <= major_pos_in;
      minor_pos_ff  <= minor_pos_in;
      major_end_ff  <= major_end_in;
      minor_down_ff <= minor_down_in;
      twice_dx_ff   <= twice_dx_in;
      twice_dy_ff   <= twice_dy_in;
      error_ff      <= error_in;
      color_ff      <= color_in;
   end

`include "line_rasterizer_assert.svh"

   `LR_ASSERT_NOW(a_emit_needs_line, clock, reset, emit, active_ff && !is_start)
   `LR_ASSERT_NEXT(a_last_ends_line, clock, reset, emit && last, !active_ff)
   `LR_ASSERT_NEXT(a_start_opens_line, clock, reset, item_valid && is_start, active_ff)

endmodule

// ----- hdl/line_rasterizer.sv -----
// Bresenham line generator. A start beat (kind 0) loads two endpoints and a color
// and produces no result; each following step beat (kind 1) returns one pixel in
// true x/y order, with last_pixel set on the final endpoint. Step beats with no
// line in progress return nothing, and a start beat abandons any line in flight.
// Coordinates are taken modulo 2^COORD_BITS. The block takes one beat per clock
// while the result register is not stalled: a beat is captured in the input
// register, and once it can be acted on, the line setup or one error-term add and
// compare runs, loading a step beat's pixel into the result register.
// A stalled result register holds back only step beats.
module line_rasterizer
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  lr_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output lr_rsp_type rsp_data
);

   logic       in_valid_ff, in_valid_in;
   lr_req_type in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   lr_rsp_type rsp_item_ff, rsp_item_in;

   logic       req_accept;
   logic       result_blocked;
   logic       walker_done;
   logic       walker_emit;
   lr_rsp_type walker_pixel;

   assign result_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall      = in_valid_ff && !walker_done;
   assign req_accept     = req_valid && !req_stall;

   lr_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_walker (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (in_valid_ff),
      .item           (in_item_ff),
      .result_blocked (result_blocked),
      .item_done      (walker_done),
      .emit           (walker_emit),
      .pixel          (walker_pixel)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (walker_done) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (walker_emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = walker_pixel;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

`include "line_rasterizer_assert.svh"

   `LR_ASSERT_NOW(a_no_overwrite, clock, reset, walker_emit, !result_blocked)
   `LR_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && result_blocked)
   `LR_ASSERT_NEXT(a_emit_shows, clock, reset, walker_emit, rsp_valid)

endmodule
